/* rtl/core/gradient_noise_2d_3d_assert.svh */
// Assertion macros for the gradient noise block.
`ifndef GRADIENT_NOISE_2D_3D_ASSERT_SVH
`define GRADIENT_NOISE_2D_3D_ASSERT_SVH
`ifndef SYNTHESIS
`define GN_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define GN_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GN_ASSERT_IMP(name, clk, rst, ante, cons)
`define GN_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/gnoise_pkg.sv */
package gnoise_pkg;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_EVAL2D = 2'd1;
   localparam logic [1:0] KIND_EVAL3D = 2'd2;

   localparam int NOISE_W = 18;
   localparam logic signed [NOISE_W-1:0] NOISE_MAX = 18'sh1FFFF;
   localparam logic signed [NOISE_W-1:0] NOISE_MIN = 18'sh20000;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         table_index;
      logic [7:0]         table_value;
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic signed [31:0] z_coord;
   } req_payload_type;

   typedef struct packed {
      logic signed [NOISE_W-1:0] noise_value;
   } rsp_payload_type;

endpackage

/* rtl/core/gnoise_if.sv */
interface gnoise_req_if;
   logic                         valid;
   logic                         ready;
   gnoise_pkg::req_payload_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface gnoise_rsp_if;
   logic                         valid;
   logic                         ready;
   gnoise_pkg::rsp_payload_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/gnoise_ram.sv */
module gnoise_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/gnoise_fade.sv */
module gnoise_fade #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [FRAC_BITS-1:0] t_in,
   output logic [FRAC_BITS:0]   fade_out
);

   localparam int FW = FRAC_BITS;
   localparam int AW = FRAC_BITS + 5;
   localparam logic signed [AW-1:0] FIFTEEN = AW'(15) << FW;
   localparam logic signed [AW-1:0] TEN = AW'(10) << FW;

   function automatic logic signed [AW-1:0] fmul(input logic [FW-1:0] t,
                                                  input logic signed [AW-1:0] x);
      logic signed [FW+AW:0] p;
      p = $signed({1'b0, t}) * x;
      return AW'(p >>> FW);
   endfunction

   logic [FW-1:0]          t1_ff, t2_ff, t3_ff;
   logic signed [AW-1:0]   b_ff, c_ff, d_ff, f_ff;
   logic signed [AW-1:0]   tt;
   logic signed [AW-1:0]   a_s;

   assign tt  = AW'(t_in);
   assign a_s = (tt <<< 2) + (tt <<< 1) - FIFTEEN;

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff <= t_in;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         b_ff  <= fmul(t_in, a_s) + TEN;
         c_ff  <= fmul(t1_ff, b_ff);
         d_ff  <= fmul(t2_ff, c_ff);
         f_ff  <= fmul(t3_ff, d_ff);
      end
   end

   assign fade_out = f_ff[FW:0];

endmodule

/* rtl/core/gradient_noise_2d_3d.sv */
// Throughput: one request per cycle while the result output is not stalled; three
// table lookup levels each have their own copies of the permutation table, and each
// fade step or lerp holds one multiply at most.
// Reset clears the pipeline valid bits; the table is undefined until loaded.
// A stalled result stalls the whole pipeline, so nothing is lost or repeated.
`include "gradient_noise_2d_3d_assert.svh"

module gradient_noise_2d_3d #(
   parameter int TABLE_DEPTH = 256,
   parameter int FRAC_BITS   = 16
) (
   input logic          clock,
   input logic          reset,
   gnoise_req_if.sink   req_chan,
   gnoise_rsp_if.source rsp_chan
);

   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int FW  = FRAC_BITS;
   localparam int VW  = FRAC_BITS + 4;
   localparam int TW  = FRAC_BITS + 1;
   localparam int SHL = (FW < 16) ? 16 - FW : 0;
   localparam int SHR = (FW > 16) ? FW - 16 : 0;
   localparam int RW  = VW + SHL;
   localparam logic signed [VW-1:0] ONE_V = VW'(1) << FW;

   function automatic logic signed [VW-1:0] lerp(input logic [TW-1:0] t,
                                                  input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
      logic signed [VW-1:0]   d;
      logic signed [TW+VW:0]  p;
      d = b - a;
      p = $signed({1'b0, t}) * d;
      return a + VW'(p >>> FW);
   endfunction

   function automatic logic signed [VW-1:0] grad(input logic [7:0] hash,
                                                  input logic d3,
                                                  input logic signed [VW-1:0] x,
                                                  input logic signed [VW-1:0] y,
                                                  input logic signed [VW-1:0] z);
      logic [3:0]           h;
      logic signed [VW-1:0] u;
      logic signed [VW-1:0] v;
      h = hash[3:0];
      if (d3) begin
         u = (h < 4'd8) ? x : y;
         if (h < 4'd4) begin
            v = y;
         end else if (h == 4'd12 || h == 4'd14) begin
            v = x;
         end else begin
            v = z;
         end
      end else begin
         u = (h[2] == 1'b0) ? x : y;
         v = (h[2] == 1'b0) ? y : x;
      end
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   logic en;
   logic acc;
   logic ev_in;
   logic ld_in;
   logic [9:1] ev_ff;
   logic [3:1] ld_ff;
   logic [7:1] d3_ff;

   logic [IW-1:0] cx1_ff, cy1_ff, cy2_ff, cz1_ff, cz2_ff, cz3_ff;
   logic [IW-1:0] idx1_ff, idx2_ff, idx3_ff;
   logic [7:0]    val1_ff, val2_ff, val3_ff;
   logic [FW-1:0] fx1_ff, fy1_ff, fz1_ff;
   logic [FW-1:0] fx2_ff, fy2_ff, fz2_ff;
   logic [FW-1:0] fx3_ff, fy3_ff, fz3_ff;
   logic [FW-1:0] fx4_ff, fy4_ff, fz4_ff;

   logic [7:0] q1 [2];
   logic [7:0] q2 [4];
   logic [7:0] q3 [8];
   logic [IW-1:0] a2, b2;
   logic [IW-1:0] addr2 [4];
   logic [IW-1:0] addr3 [8];

   logic [TW-1:0] fade_u, fade_v, fade_w;
   logic [TW-1:0] v6_ff, w6_ff, w7_ff;
   logic signed [VW-1:0] g5_ff [8];
   logic signed [VW-1:0] x6_ff [4];
   logic signed [VW-1:0] y7_ff [2];
   logic signed [VW-1:0] z8_ff;
   logic signed [gnoise_pkg::NOISE_W-1:0] out9_ff;
   logic signed [gnoise_pkg::NOISE_W-1:0] out9_in;
   logic signed [RW-1:0] r_ext;
   logic signed [RW-1:0] r_sc;

   assign en  = !ev_ff[9] || rsp_chan.ready;
   assign acc = req_chan.valid && en;
   assign req_chan.ready = en;
   assign ev_in = acc && (req_chan.payload.kind == gnoise_pkg::KIND_EVAL2D ||
                          req_chan.payload.kind == gnoise_pkg::KIND_EVAL3D);
   assign ld_in = acc && (req_chan.payload.kind == gnoise_pkg::KIND_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff <= '0;
         ld_ff <= '0;
      end else if (en) begin
         ev_ff <= {ev_ff[8:1], ev_in};
         ld_ff <= {ld_ff[2:1], ld_in};
      end
   end

   // Stage 1 splits the coordinates into cell and fraction and captures the load index and value.
   always_ff @(posedge clock) begin
      if (en) begin
         d3_ff   <= {d3_ff[6:1], req_chan.payload.kind == gnoise_pkg::KIND_EVAL3D};
         cx1_ff  <= IW'(req_chan.payload.x_coord >>> FW);
         cy1_ff  <= IW'(req_chan.payload.y_coord >>> FW);
         cz1_ff  <= (req_chan.payload.kind == gnoise_pkg::KIND_EVAL3D) ?
                    IW'(req_chan.payload.z_coord >>> FW) : '0;
         fx1_ff  <= req_chan.payload.x_coord[FW-1:0];
         fy1_ff  <= req_chan.payload.y_coord[FW-1:0];
         fz1_ff  <= req_chan.payload.z_coord[FW-1:0];
         idx1_ff <= IW'(req_chan.payload.table_index);
         val1_ff <= req_chan.payload.table_value;
         cy2_ff  <= cy1_ff;
         cz2_ff  <= cz1_ff;
         cz3_ff  <= cz2_ff;
         fx2_ff  <= fx1_ff;
         fy2_ff  <= fy1_ff;
         fz2_ff  <= fz1_ff;
         fx3_ff  <= fx2_ff;
         fy3_ff  <= fy2_ff;
         fz3_ff  <= fz2_ff;
         fx4_ff  <= fx3_ff;
         fy4_ff  <= fy3_ff;
         fz4_ff  <= fz3_ff;
         idx2_ff <= idx1_ff;
         idx3_ff <= idx2_ff;
         val2_ff <= val1_ff;
         val3_ff <= val2_ff;
      end
   end

   gnoise_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_ram_l1a (
      .clock(clock), .we(en && ld_ff[1]), .waddr(idx1_ff), .wdata(val1_ff),
      .re(en), .raddr(cx1_ff), .rdata(q1[0])
   );

   gnoise_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_ram_l1b (
      .clock(clock), .we(en && ld_ff[1]), .waddr(idx1_ff), .wdata(val1_ff),
      .re(en), .raddr(cx1_ff + 1'b1), .rdata(q1[1])
   );

   assign a2 = IW'(q1[0]) + cy2_ff;
   assign b2 = IW'(q1[1]) + cy2_ff;
   assign addr2[0] = a2;
   assign addr2[1] = a2 + 1'b1;
   assign addr2[2] = b2;
   assign addr2[3] = b2 + 1'b1;

   for (genvar i = 0; i < 4; i++) begin : g_l2
      gnoise_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_ram_l2 (
         .clock(clock), .we(en && ld_ff[2]), .waddr(idx2_ff), .wdata(val2_ff),
         .re(en), .raddr(addr2[i]), .rdata(q2[i])
      );
   end

   // Corner slot index is {x, y, z}; 2D items use the z = 0 slots only.
   for (genvar k = 0; k < 8; k++) begin : g_l3
      assign addr3[k] = IW'(q2[k/2]) + cz3_ff + IW'(k % 2);
      gnoise_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_ram_l3 (
         .clock(clock), .we(en && ld_ff[3]), .waddr(idx3_ff), .wdata(val3_ff),
         .re(en), .raddr(addr3[k]), .rdata(q3[k])
      );
   end

   gnoise_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
      .clock(clock), .en(en), .t_in(fx1_ff), .fade_out(fade_u)
   );

   gnoise_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
      .clock(clock), .en(en), .t_in(fy1_ff), .fade_out(fade_v)
   );

   gnoise_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
      .clock(clock), .en(en), .t_in(fz1_ff), .fade_out(fade_w)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 8; k++) begin
            g5_ff[k] <= grad(q3[k], d3_ff[4],
                             VW'(fx4_ff) - (((k / 4) % 2 == 1) ? ONE_V : '0),
                             VW'(fy4_ff) - (((k / 2) % 2 == 1) ? ONE_V : '0),
                             VW'(fz4_ff) - ((k % 2 == 1) ? ONE_V : '0));
         end
         for (int j = 0; j < 4; j++) begin
            x6_ff[j] <= lerp(fade_u, g5_ff[j], g5_ff[j+4]);
         end
         v6_ff <= fade_v;
         w6_ff <= fade_w;
         for (int j = 0; j < 2; j++) begin
            y7_ff[j] <= lerp(v6_ff, x6_ff[j], x6_ff[j+2]);
         end
         w7_ff <= w6_ff;
         z8_ff <= d3_ff[7] ? lerp(w7_ff, y7_ff[0], y7_ff[1]) : y7_ff[0];
         out9_ff <= out9_in;
      end
   end

   always_comb begin
      r_ext = RW'(z8_ff);
      r_sc  = (r_ext <<< SHL) >>> SHR;
      if (r_sc > RW'(gnoise_pkg::NOISE_MAX)) begin
         out9_in = gnoise_pkg::NOISE_MAX;
      end else if (r_sc < RW'(gnoise_pkg::NOISE_MIN)) begin
         out9_in = gnoise_pkg::NOISE_MIN;
      end else begin
         out9_in = gnoise_pkg::NOISE_W'(r_sc);
      end
   end

   assign rsp_chan.valid = ev_ff[9];
   assign rsp_chan.payload.noise_value = out9_ff;

   `GN_ASSERT_IMP(a_stall_blocks_input, clock, reset, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready)
   `GN_ASSERT_NXT(a_load_enters, clock, reset, req_chan.valid && req_chan.ready && req_chan.payload.kind == gnoise_pkg::KIND_LOAD, ld_ff[1] && !ev_ff[1])
   `GN_ASSERT_IMP(a_load_not_eval, clock, reset, ld_ff[2] || ld_ff[3], !ev_ff[2] || !ld_ff[2])

endmodule
